// ===== hdl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Heap geometry, table sizing, request and response words, cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

   // Heap geometry (ALIGN_BYTES is a power of two)
   localparam int unsigned HEAP_BYTES      = 65536;
   localparam int unsigned HEADER_BYTES    = 24;
   localparam int unsigned ALIGN_BYTES     = 8;
   localparam int unsigned MAX_FREE_BLOCKS = 64;

   localparam int unsigned HDR =
      ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int unsigned HEAP_USE    = (HEAP_BYTES / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int unsigned STORE_DEPTH = HEAP_BYTES / ALIGN_BYTES;
   localparam int unsigned INIT_SIZE   = HEAP_USE - HDR;

   localparam int unsigned FIELD_W  = 16;
   localparam int unsigned ALIGN_SH = $clog2(ALIGN_BYTES);
   localparam int unsigned ADDR_W   = $clog2(HEAP_BYTES);
   localparam int unsigned SUM_W    = ADDR_W + 2;
   localparam int unsigned NEED_W   = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 2;
   localparam int unsigned IDX_W    = $clog2(MAX_FREE_BLOCKS);
   localparam int unsigned CNT_W    = $clog2(MAX_FREE_BLOCKS + 1);
   localparam int unsigned SIDX_W   = $clog2(STORE_DEPTH);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NO_FIT = 2'd1,
      ST_FULL   = 2'd2,
      ST_BAD    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [FIELD_W-1:0] alloc_size;
      logic [FIELD_W-1:0] free_addr;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] payload_addr;
   } rsp_type;

   // One free block held by a cell
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
   } entry_type;

   // Word that travels down the cell chain during a scan
   typedef struct packed {
      logic              fit_hit;
      logic [IDX_W-1:0]  fit_idx;
      logic [ADDR_W-1:0] fit_start;
      logic [ADDR_W-1:0] fit_size;
      logic              pred_hit;
      logic [IDX_W-1:0]  pred_idx;
      logic [ADDR_W-1:0] pred_start;
      logic [ADDR_W-1:0] pred_size;
      logic              succ_hit;
      logic [IDX_W-1:0]  succ_idx;
      logic [ADDR_W-1:0] succ_start;
      logic [ADDR_W-1:0] succ_size;
   } scan_type;

   // Update broadcast to all cells
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_idx;
      logic              ins_en;
      logic              del_en;
      logic [IDX_W-1:0]  sh_idx;
      logic [ADDR_W-1:0] new_start;
      logic [ADDR_W-1:0] new_size;
   } upd_type;

endpackage

`default_nettype wire

// ===== hdl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap allocator with coalescing
// Address-ordered free-block table in a chain of cells, allocated sizes in a
// block RAM indexed by payload address.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one allocate or free word.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one status word per
//   request, with the payload address of a successful allocate.
//   One request is in flight at a time. From acceptance to the response
//   register, the keys are latched at the accepting edge, the scan state
//   carries the scan word down the cell chain, and the apply step updates
//   the table and loads the response. The next request is taken in the
//   idle state that follows the apply step.
//   A finished response sits in its output register while the next request
//   is accepted and scanned; a second result waits in the apply step until
//   the receiver takes the first.
//   Reset leaves one free block covering the whole heap; the size RAM is not
//   cleared and a free of a never-allocated address is unsupported.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator import ffha_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   req_type           req_ff, req_in;
   logic [NEED_W-1:0] need_r_ff, need_r_in;
   logic [ADDR_W-1:0] key_b_ff, key_b_in;
   logic              bad_addr_ff, bad_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   upd_type           upd;
   scan_type          sr;

   // Size RAM
   logic [ADDR_W-1:0] store_mem [STORE_DEPTH];
   logic [ADDR_W-1:0] store_q_ff;
   logic              st_we;
   logic [SIDX_W-1:0] st_wa, st_ra;
   logic [ADDR_W-1:0] st_wd;

   // Decide-step values
   logic [NEED_W-1:0] rnd;
   logic [NEED_W-1:0] n_ext;
   logic              split;
   logic [SUM_W-1:0]  pred_end, blk_end;
   logic              mp, ms;
   logic [IDX_W-1:0]  pos;
   logic [ADDR_W-1:0] pay_addr;
   logic              go;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   ffha_table u_table (
      .clock    (clock),
      .reset    (reset),
      .need_r   (need_r_ff),
      .key_b    (key_b_ff),
      .upd      (upd),
      .scan_res (sr)
   );

   // Request keys
   always_comb begin
      n_ext       = NEED_W'(req_data.alloc_size);
      rnd         = ((n_ext + NEED_W'(ALIGN_BYTES - 1)) >> ALIGN_SH) << ALIGN_SH;
      need_r_in   = rnd + NEED_W'(HDR);
      key_b_in    = ADDR_W'(32'(req_data.free_addr) - 32'(HDR));
      bad_addr_in = ((32'(req_data.free_addr) & 32'(ALIGN_BYTES - 1)) != 32'd0) ||
                    (32'(req_data.free_addr) < HDR) ||
                    (32'(req_data.free_addr) >= HEAP_USE);
   end

   // Merge tests and insert position for a free, split test and payload address for an allocate
   always_comb begin
      pred_end = SUM_W'(sr.pred_start) + SUM_W'(HDR) + SUM_W'(sr.pred_size);
      blk_end  = SUM_W'(key_b_ff) + SUM_W'(HDR) + SUM_W'(store_q_ff);
      mp       = sr.pred_hit && (pred_end == SUM_W'(key_b_ff));
      ms       = sr.succ_hit && (blk_end == SUM_W'(sr.succ_start));
      pos      = sr.succ_hit ? sr.succ_idx : IDX_W'(cnt_ff);
      split    = NEED_W'(sr.fit_size) >= (need_r_ff + NEED_W'(HDR));
      pay_addr = sr.fit_start + ADDR_W'(HDR);
      go       = !rsp_valid_ff || rsp_ready;
      st_ra    = SIDX_W'(req_ff.free_addr >> ALIGN_SH);
   end

   // Sequencer: next state, table update, RAM write, response
   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      upd          = '0;
      st_we        = 1'b0;
      st_wa        = st_ra;
      st_wd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               scan_cnt_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == IDX_W'(MAX_FREE_BLOCKS - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (go) begin
               state_in            = S_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_in.payload_addr = '0;
               rsp_in.status       = ST_OK;
               if (req_ff.op == OP_ALLOC) begin
                  if (req_ff.alloc_size == '0) begin
                     rsp_in.status = ST_BAD;
                  end else if (!sr.fit_hit) begin
                     rsp_in.status = ST_NO_FIT;
                  end else begin
                     rsp_in.payload_addr = FIELD_W'(pay_addr);
                     st_we = 1'b1;
                     st_wa = SIDX_W'(pay_addr >> ALIGN_SH);
                     if (split) begin
                        upd.wr_en     = 1'b1;
                        upd.wr_idx    = sr.fit_idx;
                        upd.new_start = sr.fit_start + ADDR_W'(need_r_ff);
                        upd.new_size  = sr.fit_size - ADDR_W'(need_r_ff);
                        st_wd         = ADDR_W'(need_r_ff - NEED_W'(HDR));
                     end else begin
                        upd.del_en = 1'b1;
                        upd.sh_idx = sr.fit_idx;
                        st_wd      = sr.fit_size;
                        cnt_in     = cnt_ff - 1'b1;
                     end
                  end
               end else begin
                  if (bad_addr_ff || (store_q_ff == '0)) begin
                     rsp_in.status = ST_BAD;
                  end else if (mp && ms) begin
                     upd.wr_en     = 1'b1;
                     upd.wr_idx    = sr.pred_idx;
                     upd.new_start = sr.pred_start;
                     upd.new_size  = sr.pred_size + ADDR_W'(HDR) + store_q_ff +
                                     ADDR_W'(HDR) + sr.succ_size;
                     upd.del_en    = 1'b1;
                     upd.sh_idx    = sr.succ_idx;
                     cnt_in        = cnt_ff - 1'b1;
                     st_we         = 1'b1;
                  end else if (mp) begin
                     upd.wr_en     = 1'b1;
                     upd.wr_idx    = sr.pred_idx;
                     upd.new_start = sr.pred_start;
                     upd.new_size  = sr.pred_size + ADDR_W'(HDR) + store_q_ff;
                     st_we         = 1'b1;
                  end else if (ms) begin
                     upd.wr_en     = 1'b1;
                     upd.wr_idx    = sr.succ_idx;
                     upd.new_start = key_b_ff;
                     upd.new_size  = store_q_ff + ADDR_W'(HDR) + sr.succ_size;
                     st_we         = 1'b1;
                  end else if (cnt_ff == CNT_W'(MAX_FREE_BLOCKS)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     upd.ins_en    = 1'b1;
                     upd.sh_idx    = pos;
                     upd.new_start = key_b_ff;
                     upd.new_size  = store_q_ff;
                     cnt_in        = cnt_ff + 1'b1;
                     st_we         = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      if (state_ff == S_IDLE) begin
         need_r_ff   <= need_r_in;
         key_b_ff    <= key_b_in;
         bad_addr_ff <= bad_addr_in;
      end
   end

   // Size RAM: one write, one registered read
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_wa] <= st_wd;
      end
      store_q_ff <= store_mem[st_ra];
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_FREE_BLOCKS))
      else $error("free count above table size");

   a_cnt_only_apply: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (cnt_ff != $past(cnt_ff))) |-> $past(state_ff == S_DECIDE))
      else $error("free count changed outside apply step");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == S_DECIDE))
      else $error("response raised outside apply step");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ST_OK)) |-> (rsp_ff.payload_addr == '0))
      else $error("failed request returned an address");
`endif

endmodule

`default_nettype wire

// ===== hdl/ffha_cell.sv =====
// ----------------------------------------------------------------------------
// ffha_cell: one slot of the free-block table
// Holds one free block, shifts it with its neighbors on insert or delete and
// contributes its match to the scan word passing down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_cell import ffha_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [IDX_W-1:0]  cell_idx,
   input  wire entry_type         left_entry,
   input  wire entry_type         right_entry,
   input  wire logic              left_le,
   input  wire logic              right_le,
   output entry_type              entry,
   output logic                   le,
   input  wire logic [NEED_W-1:0] need_r,
   input  wire logic [ADDR_W-1:0] key_b,
   input  wire upd_type           upd,
   input  wire scan_type          scan_in,
   output scan_type               scan_out
);

   entry_type entry_ff, entry_in;
   scan_type  scan_ff, scan_in_next;
   logic      fit_here, pred_here, succ_here;

   assign entry    = entry_ff;
   assign scan_out = scan_ff;

   // Local matches against the broadcast keys
   assign le        = entry_ff.valid && (entry_ff.start <= key_b);
   assign fit_here  = entry_ff.valid && (NEED_W'(entry_ff.size) >= need_r);
   assign pred_here = le && !right_le;
   assign succ_here = entry_ff.valid && !le && left_le;

   // Merge this slot into the scan word
   always_comb begin
      scan_in_next = scan_in;
      if (!scan_in.fit_hit && fit_here) begin
         scan_in_next.fit_hit   = 1'b1;
         scan_in_next.fit_idx   = cell_idx;
         scan_in_next.fit_start = entry_ff.start;
         scan_in_next.fit_size  = entry_ff.size;
      end
      if (pred_here) begin
         scan_in_next.pred_hit   = 1'b1;
         scan_in_next.pred_idx   = cell_idx;
         scan_in_next.pred_start = entry_ff.start;
         scan_in_next.pred_size  = entry_ff.size;
      end
      if (succ_here) begin
         scan_in_next.succ_hit   = 1'b1;
         scan_in_next.succ_idx   = cell_idx;
         scan_in_next.succ_start = entry_ff.start;
         scan_in_next.succ_size  = entry_ff.size;
      end
   end

   // Hold, overwrite, or shift from a neighbor
   always_comb begin
      entry_in = entry_ff;
      if (upd.ins_en) begin
         if (cell_idx > upd.sh_idx) begin
            entry_in = left_entry;
         end else if (cell_idx == upd.sh_idx) begin
            entry_in.valid = 1'b1;
            entry_in.start = upd.new_start;
            entry_in.size  = upd.new_size;
         end
      end
      if (upd.del_en && (cell_idx >= upd.sh_idx)) begin
         entry_in = right_entry;
      end
      if (upd.wr_en && (cell_idx == upd.wr_idx)) begin
         entry_in.start = upd.new_start;
         entry_in.size  = upd.new_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= (cell_idx == '0);
         entry_ff.start <= '0;
         entry_ff.size  <= ADDR_W'(INIT_SIZE);
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in_next;
   end

endmodule

`default_nettype wire

// ===== hdl/ffha_table.sv =====
// ----------------------------------------------------------------------------
// ffha_table: chain of free-block cells
// Links the cells to their neighbors and carries the scan word from the first
// cell to the last, one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_table import ffha_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [NEED_W-1:0] need_r,
   input  wire logic [ADDR_W-1:0] key_b,
   input  wire upd_type           upd,
   output scan_type               scan_res
);

   entry_type ents [MAX_FREE_BLOCKS];
   logic      les  [MAX_FREE_BLOCKS];
   scan_type  chain [MAX_FREE_BLOCKS+1];

   // Empty word enters the head of the chain every cycle
   assign chain[0] = '0;
   assign scan_res = chain[MAX_FREE_BLOCKS];

   for (genvar i = 0; i < MAX_FREE_BLOCKS; i++) begin : g_cell
      entry_type l_ent, r_ent;
      logic      l_le, r_le;

      if (i == 0) begin : g_first
         assign l_ent = '0;
         assign l_le  = 1'b1;
      end else begin : g_mid_l
         assign l_ent = ents[i-1];
         assign l_le  = les[i-1];
      end

      if (i == MAX_FREE_BLOCKS - 1) begin : g_last
         assign r_ent = '0;
         assign r_le  = 1'b0;
      end else begin : g_mid_r
         assign r_ent = ents[i+1];
         assign r_le  = les[i+1];
      end

      ffha_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(i)),
         .left_entry  (l_ent),
         .right_entry (r_ent),
         .left_le     (l_le),
         .right_le    (r_le),
         .entry       (ents[i]),
         .le          (les[i]),
         .need_r      (need_r),
         .key_b       (key_b),
         .upd         (upd),
         .scan_in     (chain[i]),
         .scan_out    (chain[i+1])
      );
   end

endmodule

`default_nettype wire
